/* rtl/glw_pkg.sv */
package glw_pkg;

    // field widths of one character word
    localparam int CODE_W    = 21;
    localparam int TEX_W     = 16;
    localparam int METRIC_W  = 10;
    localparam int ADV_W     = 16;
    localparam int ADV_FRAC  = 6;
    localparam int REG_W     = 24;
    localparam int PEN_W     = 25;
    localparam int DIST_W    = 26;
    localparam int MAG_W     = 27;
    localparam int COORD_W   = 26;
    localparam int SUM_W     = 29;
    localparam int PROD_W    = METRIC_W + REG_W;
    localparam int SLOT_IDX_W = 12;

    // packed stream widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 128;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

    // register reset values
    localparam logic [REG_W-1:0] GLYPH_SCALE_RST = 24'd65536;
    localparam logic [REG_W-1:0] LINE_HEIGHT_RST = 24'd4096;
    localparam logic [REG_W-1:0] LINE_STEP_RST   = 24'd4506;
    localparam logic [REG_W-1:0] BOX_WIDTH_RST   = 24'd16777215;
    localparam logic [REG_W-1:0] BOX_HEIGHT_RST  = 24'd16777215;

    localparam logic signed [SUM_W-1:0] S26_MAX = SUM_W'(33554431);
    localparam logic signed [SUM_W-1:0] S26_MIN = -SUM_W'(33554432);

    typedef enum logic [2:0] {
        CFG_GLYPH_SCALE = 3'd0,
        CFG_LINE_HEIGHT = 3'd1,
        CFG_LINE_STEP   = 3'd2,
        CFG_BOX_WIDTH   = 3'd3,
        CFG_BOX_HEIGHT  = 3'd4,
        CFG_MULTILINE   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] unit_scale;
        logic [REG_W-1:0] line_height;
        logic [REG_W-1:0] line_step;
        logic [REG_W-1:0] box_width;
        logic [REG_W-1:0] box_height;
        logic             multiline;
    } glw_cfg_t;

    // classified and scaled character, as queued for the back end
    typedef struct packed {
        logic              start;
        logic              newline;
        logic              drawable;
        logic [TEX_W-1:0]  texture;
        logic [DIST_W-1:0] adv_px;
        logic [REG_W-1:0]  draw_w;
        logic [REG_W-1:0]  draw_h;
        logic              bx_neg;
        logic [MAG_W-1:0]  bx_mag;
        logic              by_neg;
        logic [MAG_W-1:0]  by_mag;
    } glw_item_t;

    function automatic logic [COORD_W-1:0] sat_s26(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > S26_MAX)
        begin
            r = S26_MAX[COORD_W-1:0];
        end
        else if (v < S26_MIN)
        begin
            r = S26_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/glyph_layout_line_wrap_core.sv */
// glyph layout with line wrap
// s_* carries one character word per handshake: s_tuser is start_of_text,
// s_tdata the code point, texture handle and glyph metrics. m_* carries one
// placed glyph word: slot index, texture, scaled size and offset. A character
// gives zero or one glyph word; multiline newlines, wraps that leave the box
// and characters after a halt give none.
// cfg_we/cfg_index/cfg_data write the six layout registers; write them only
// while no character is in flight.
// A glyph word passes the front multiply register, the queue and the output
// register before it shows on m_tvalid.
// Throughput: one character per cycle while m_tready keeps the output open;
// the pen update in the back end is the only loop.
// A four-word queue separates the multiply front from the pen back end, and
// s_tready follows m_tready combinationally once that queue is full, so a
// stalled receiver holds the input off after the queue and front stage fill.
// Reset clears the pen to the origin of the first row, the slot count, the
// halted flag, the queue and the registers to their defaults; no clear pass.
module glyph_layout_line_wrap_core #(
    parameter int MAX_SLOTS       = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code, texture_id, glyph width, glyph height, x bearing, y bearing,
    // advance_units, zero pad
    input  logic [glw_pkg::IN_TDATA_W-1:0]      s_tdata,
    // start_of_text
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot_index, out_texture, draw_width, draw_height, draw_x, draw_y
    output logic [glw_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [glw_pkg::REG_W-1:0]           cfg_data
);

    glw_pkg::glw_cfg_t  cfg_reg;
    glw_pkg::glw_item_t front_item;
    glw_pkg::glw_item_t queue_item;
    logic               front_valid;
    logic               front_ready;
    logic               queue_valid;
    logic               queue_ready;

    logic [glw_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [glw_pkg::TEX_W-1:0]      out_texture;
    logic [glw_pkg::REG_W-1:0]      draw_width;
    logic [glw_pkg::REG_W-1:0]      draw_height;
    logic [glw_pkg::COORD_W-1:0]    draw_x;
    logic [glw_pkg::COORD_W-1:0]    draw_y;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_scale  <= glw_pkg::GLYPH_SCALE_RST;
            cfg_reg.line_height <= glw_pkg::LINE_HEIGHT_RST;
            cfg_reg.line_step   <= glw_pkg::LINE_STEP_RST;
            cfg_reg.box_width   <= glw_pkg::BOX_WIDTH_RST;
            cfg_reg.box_height  <= glw_pkg::BOX_HEIGHT_RST;
            cfg_reg.multiline   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (glw_pkg::cfg_idx_t'(cfg_index))
                glw_pkg::CFG_GLYPH_SCALE: cfg_reg.unit_scale  <= cfg_data;
                glw_pkg::CFG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data;
                glw_pkg::CFG_LINE_STEP:   cfg_reg.line_step   <= cfg_data;
                glw_pkg::CFG_BOX_WIDTH:   cfg_reg.box_width   <= cfg_data;
                glw_pkg::CFG_BOX_HEIGHT:  cfg_reg.box_height  <= cfg_data;
                glw_pkg::CFG_MULTILINE:   cfg_reg.multiline   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // scaling front end
    glw_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .start         (s_tuser),
        .char_code     (s_tdata[20:0]),
        .texture_id    (s_tdata[36:21]),
        .glyph_width   (s_tdata[46:37]),
        .glyph_h       (s_tdata[56:47]),
        .bx_raw        (s_tdata[66:57]),
        .by_raw        (s_tdata[76:67]),
        .advance_units (s_tdata[92:77]),
        .unit_scale    (cfg_reg.unit_scale),
        .out_valid     (front_valid),
        .out_item      (front_item),
        .out_ready     (front_ready)
    );

    // decoupling queue
    glw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // pen and placement back end
    glw_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .slot_index  (slot_index),
        .out_texture (out_texture),
        .draw_width  (draw_width),
        .draw_height (draw_height),
        .draw_x      (draw_x),
        .draw_y      (draw_y)
    );

    assign m_tdata = {draw_y, draw_x, draw_height, draw_width, out_texture, slot_index};

endmodule

/* rtl/glw_front.sv */
module glw_front #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 start,
    input  logic [glw_pkg::CODE_W-1:0]           char_code,
    input  logic [glw_pkg::TEX_W-1:0]            texture_id,
    input  logic [glw_pkg::METRIC_W-1:0]         glyph_width,
    input  logic [glw_pkg::METRIC_W-1:0]         glyph_h,
    input  logic [glw_pkg::METRIC_W-1:0]         bx_raw,
    input  logic [glw_pkg::METRIC_W-1:0]         by_raw,
    input  logic [glw_pkg::ADV_W-1:0]            advance_units,
    input  logic [glw_pkg::REG_W-1:0]            unit_scale,
    output logic                                 out_valid,
    output glw_pkg::glw_item_t                   out_item,
    input  logic                                 out_ready
);

    localparam int SCALE_SHIFT = 16 - COORD_FRAC_BITS;
    localparam int PW = glw_pkg::PROD_W;
    localparam int MW = glw_pkg::METRIC_W;

    logic          st_valid_reg;
    logic          start_reg;
    logic          newline_reg;
    logic          drawable_reg;
    logic [glw_pkg::TEX_W-1:0] tex_reg;
    logic [PW-1:0] dist_reg;
    logic [PW-1:0] width_reg;
    logic [PW-1:0] height_reg;
    logic          bx_neg_reg;
    logic [PW-1:0] bx_reg;
    logic          by_neg_reg;
    logic [PW-1:0] by_reg;

    logic [MW-1:0] adv_int;
    logic [MW-1:0] bx_mag;
    logic [MW-1:0] by_mag;
    logic [PW-1:0] dist_prod;
    logic [PW-1:0] width_prod;
    logic [PW-1:0] height_prod;
    logic [PW-1:0] bx_prod;
    logic [PW-1:0] by_prod;
    logic          take;

    assign in_ready = !st_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // integer advance and bearing magnitudes
    assign adv_int = MW'(advance_units[glw_pkg::ADV_W-1:glw_pkg::ADV_FRAC]);
    assign bx_mag  = bx_raw[MW-1] ? MW'(-bx_raw) : bx_raw;
    assign by_mag  = by_raw[MW-1] ? MW'(-by_raw) : by_raw;

    // independent scaling multiplies, truncated toward zero
    assign dist_prod   = (PW'(adv_int) * PW'(unit_scale)) >> SCALE_SHIFT;
    assign width_prod  = (PW'(glyph_width) * PW'(unit_scale)) >> SCALE_SHIFT;
    assign height_prod = (PW'(glyph_h) * PW'(unit_scale)) >> SCALE_SHIFT;
    assign bx_prod     = (PW'(bx_mag) * PW'(unit_scale)) >> SCALE_SHIFT;
    assign by_prod     = (PW'(by_mag) * PW'(unit_scale)) >> SCALE_SHIFT;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            st_valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg    <= start;
            newline_reg  <= (char_code == glw_pkg::NEWLINE_CODE);
            drawable_reg <= (glyph_width != '0);
            tex_reg      <= texture_id;
            dist_reg     <= dist_prod;
            width_reg    <= width_prod;
            height_reg   <= height_prod;
            bx_neg_reg   <= bx_raw[MW-1];
            bx_reg       <= bx_prod;
            by_neg_reg   <= by_raw[MW-1];
            by_reg       <= by_prod;
        end
    end

    // clamp products to the widths the back end can tell apart
    always_comb
    begin
        out_item.start    = start_reg;
        out_item.newline  = newline_reg;
        out_item.drawable = drawable_reg;
        out_item.texture  = tex_reg;
        out_item.adv_px   = (dist_reg[PW-1:glw_pkg::DIST_W] != '0) ? '1
                            : dist_reg[glw_pkg::DIST_W-1:0];
        out_item.draw_w   = (width_reg[PW-1:glw_pkg::REG_W] != '0) ? '1
                            : width_reg[glw_pkg::REG_W-1:0];
        out_item.draw_h   = (height_reg[PW-1:glw_pkg::REG_W] != '0) ? '1
                            : height_reg[glw_pkg::REG_W-1:0];
        out_item.bx_neg   = bx_neg_reg;
        out_item.bx_mag   = (bx_reg[PW-1:glw_pkg::MAG_W-1] != '0)
                            ? {1'b1, {(glw_pkg::MAG_W-1){1'b0}}}
                            : bx_reg[glw_pkg::MAG_W-1:0];
        out_item.by_neg   = by_neg_reg;
        out_item.by_mag   = (by_reg[PW-1:glw_pkg::MAG_W-1] != '0)
                            ? {1'b1, {(glw_pkg::MAG_W-1){1'b0}}}
                            : by_reg[glw_pkg::MAG_W-1:0];
    end

    assign out_valid = st_valid_reg;

endmodule

/* rtl/glw_queue.sv */
module glw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  glw_pkg::glw_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output glw_pkg::glw_item_t pop_item
);

    glw_pkg::glw_item_t mem_reg [glw_pkg::QUEUE_DEPTH];

    logic [glw_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [glw_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [glw_pkg::QCNT_W-1:0] count_reg;
    logic [glw_pkg::QCNT_W-1:0] count_next;
    logic                       push;
    logic                       pop;

    assign pop_valid  = (count_reg != '0);
    assign pop        = pop_valid && pop_ready;
    assign push_ready = (count_reg != glw_pkg::QCNT_W'(glw_pkg::QUEUE_DEPTH)) || pop;
    assign push       = push_valid && push_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + glw_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - glw_pkg::QCNT_W'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + glw_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + glw_pkg::QPTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/glw_back.sv */
module glw_back #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  glw_pkg::glw_item_t                 in_item,
    input  glw_pkg::glw_cfg_t                  cfg,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [glw_pkg::SLOT_IDX_W-1:0]     slot_index,
    output logic [glw_pkg::TEX_W-1:0]          out_texture,
    output logic [glw_pkg::REG_W-1:0]          draw_width,
    output logic [glw_pkg::REG_W-1:0]          draw_height,
    output logic [glw_pkg::COORD_W-1:0]        draw_x,
    output logic [glw_pkg::COORD_W-1:0]        draw_y
);

    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int IDX_EW = (CNT_W > glw_pkg::SLOT_IDX_W) ? CNT_W : glw_pkg::SLOT_IDX_W;
    localparam int PW     = glw_pkg::PEN_W;
    localparam int SW     = glw_pkg::SUM_W;

    logic [PW-1:0]    pen_x_reg, pen_x_next;
    logic [PW-1:0]    pen_y_reg, pen_y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             halted_reg, halted_next;
    logic             out_valid_reg;
    logic             emit;
    logic             pop;

    logic [glw_pkg::SLOT_IDX_W-1:0] slot_reg;
    logic [glw_pkg::TEX_W-1:0]      tex_reg;
    logic [glw_pkg::REG_W-1:0]      dw_reg;
    logic [glw_pkg::REG_W-1:0]      dh_reg;
    logic [glw_pkg::COORD_W-1:0]    dx_reg;
    logic [glw_pkg::COORD_W-1:0]    dy_reg;

    logic [PW-1:0]       px0, py0, py_nl, px_b, py_b, px_adv;
    logic [CNT_W-1:0]    cnt0, cnt1;
    logic                h0, has_slot, nl_halt, over, wrap;
    logic [PW:0]         step_sum;
    logic [PW+1:0]       adv_sum;
    logic [IDX_EW-1:0]   slot_wide;
    logic signed [SW-1:0] bx_s, by_s, dx_full, dy_full;

    assign pop      = in_valid && (!out_valid_reg || out_ready);
    assign in_ready = !out_valid_reg || out_ready;

    // pen, slot and wrap decisions for the character at the queue head
    always_comb
    begin
        px0  = in_item.start ? '0 : pen_x_reg;
        py0  = in_item.start ? PW'(cfg.line_height) : pen_y_reg;
        cnt0 = in_item.start ? '0 : cnt_reg;
        h0   = in_item.start ? 1'b0 : halted_reg;

        has_slot = in_item.drawable && (cnt0 < CNT_W'(MAX_SLOTS));
        cnt1     = cnt0 + CNT_W'(has_slot);

        step_sum = {1'b0, py0} + (PW+1)'(cfg.line_step);
        py_nl    = step_sum[PW] ? '1 : step_sum[PW-1:0];
        nl_halt  = py_nl > PW'(cfg.box_height);

        adv_sum = (PW+2)'(px0) + (PW+2)'(in_item.adv_px);
        over    = adv_sum > (PW+2)'(cfg.box_width);
        wrap    = over && cfg.multiline;

        px_b    = wrap ? '0 : px0;
        py_b    = wrap ? py_nl : py0;
        adv_sum = (PW+2)'(px_b) + (PW+2)'(in_item.adv_px);
        px_adv  = (adv_sum[PW+1:PW] != '0) ? '1 : adv_sum[PW-1:0];

        bx_s    = $signed(SW'(in_item.bx_mag));
        by_s    = $signed(SW'(in_item.by_mag));
        dx_full = in_item.bx_neg ? $signed(SW'(px_b)) - bx_s : $signed(SW'(px_b)) + bx_s;
        dy_full = in_item.by_neg ? $signed(SW'(py_b)) + by_s : $signed(SW'(py_b)) - by_s;

        slot_wide = IDX_EW'(cnt1 - CNT_W'(1));
    end

    // next state
    always_comb
    begin
        pen_x_next  = px0;
        pen_y_next  = py0;
        cnt_next    = cnt0;
        halted_next = h0;
        emit        = 1'b0;
        if (!h0)
        begin
            cnt_next = cnt1;
            if (in_item.newline && cfg.multiline)
            begin
                pen_x_next  = '0;
                pen_y_next  = py_nl;
                halted_next = nl_halt;
            end
            else if (over && !cfg.multiline)
            begin
                halted_next = 1'b1;
            end
            else if (wrap && nl_halt)
            begin
                pen_x_next  = '0;
                pen_y_next  = py_nl;
                halted_next = 1'b1;
            end
            else
            begin
                pen_x_next = px_adv;
                pen_y_next = py_b;
                emit       = has_slot;
            end
        end
    end

    // layout state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= PW'(glw_pkg::LINE_HEIGHT_RST);
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (pop)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            slot_reg <= slot_wide[glw_pkg::SLOT_IDX_W-1:0];
            tex_reg  <= in_item.texture;
            dw_reg   <= in_item.draw_w;
            dh_reg   <= in_item.draw_h;
            dx_reg   <= glw_pkg::sat_s26(dx_full);
            dy_reg   <= glw_pkg::sat_s26(dy_full);
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_index  = slot_reg;
    assign out_texture = tex_reg;
    assign draw_width  = dw_reg;
    assign draw_height = dh_reg;
    assign draw_x      = dx_reg;
    assign draw_y      = dy_reg;

endmodule

/* rtl/glw_checker.sv */
module glw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [glw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled glyph word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("glyph word dropped while stalled");

    // a stalled glyph word keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("glyph word changed while stalled");

    // in reset nothing is offered and the input is open
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid && s_tready)
    else $error("reset state not idle");

    // a draining receiver never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
    else $error("input blocked while output drains");

    // an empty output register leaves the input open, offered or not
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && (s_tvalid || !s_tvalid) |-> s_tready)
    else $error("input blocked with no glyph word waiting");

endmodule

bind glyph_layout_line_wrap_core glw_checker u_glw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
